/* sv/sha1bs_pkg.sv */
// Shared types and constants for the SHA-1 byte stream hash core.
// No dependencies; imported by the round unit and the top level.
package sha1bs_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned DIGEST_N = 5;
    localparam int unsigned BLOCK_N  = 16;

    // initial chaining value
    localparam logic [WORD_W-1:0] IV_WORDS [DIGEST_N] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    // round constants, one per group of 20 rounds
    localparam logic [WORD_W-1:0] K_GRP0 = 32'h5A827999;
    localparam logic [WORD_W-1:0] K_GRP1 = 32'h6ED9EBA1;
    localparam logic [WORD_W-1:0] K_GRP2 = 32'h8F1BBCDC;
    localparam logic [WORD_W-1:0] K_GRP3 = 32'hCA62C1D6;

    localparam logic [6:0] RND_GRP1_START = 7'd20;
    localparam logic [6:0] RND_GRP2_START = 7'd40;
    localparam logic [6:0] RND_GRP3_START = 7'd60;
    localparam logic [6:0] RND_LAST       = 7'd79;

    localparam logic [7:0] PAD_MARK       = 8'h80;
    localparam logic [5:0] FILL_LAST      = 6'd63;
    localparam logic [5:0] FILL_LEN_START = 6'd56;
    localparam logic [63:0] BITS_PER_BYTE = 64'd8;
    localparam logic [2:0] OUT_LAST_IDX   = 3'd4;

    // working variables of the compression
    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] d;
        logic [WORD_W-1:0] e;
    } work_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_ADD   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

endpackage

/* sv/sha1bs_round.sv */
// One SHA-1 round: the shared round unit reused for all 80 rounds.
// Depends on sha1bs_pkg (work_t, round constants).
module sha1bs_round (
    input  sha1bs_pkg::work_t  cur,
    input  logic [31:0]        w_word,
    input  logic [6:0]         round_idx,
    output sha1bs_pkg::work_t  nxt
);
    import sha1bs_pkg::*;

    logic [WORD_W-1:0] f_val;
    logic [WORD_W-1:0] k_val;
    logic [WORD_W-1:0] temp;

    always_comb begin
        priority if (round_idx < RND_GRP1_START) begin
            f_val = (cur.b & cur.c) | (~cur.b & cur.d);
            k_val = K_GRP0;
        end else if (round_idx < RND_GRP2_START) begin
            f_val = cur.b ^ cur.c ^ cur.d;
            k_val = K_GRP1;
        end else if (round_idx < RND_GRP3_START) begin
            f_val = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
            k_val = K_GRP2;
        end else begin
            f_val = cur.b ^ cur.c ^ cur.d;
            k_val = K_GRP3;
        end
    end

    assign temp = {cur.a[26:0], cur.a[31:27]} + f_val + cur.e + w_word + k_val;

    always_comb begin
        nxt.a = temp;
        nxt.b = cur.a;
        nxt.c = {cur.b[1:0], cur.b[31:2]};
        nxt.d = cur.c;
        nxt.e = cur.d;
    end

endmodule

/* sv/sha1_byte_stream_hash_core.sv */
// SHA-1 byte stream hash core: top level with byte packing, padding,
// message schedule and sequencer. Depends on sha1bs_pkg and sha1bs_round.
//
// Usage:
//  - Slave channel: one transaction per message byte. s_tuser[0] says the
//    s_tdata byte belongs to the message; s_tlast ends the message. A
//    transaction with s_tlast and no byte finalizes (also the empty message).
//  - Master channel: after an end transaction, five transactions carry the
//    digest words, most significant first; m_tuser holds the word index and
//    m_tlast marks the fifth word.
//  - Input: a byte that does not complete a block is accepted without
//    stalling. The byte that completes a 64-byte block starts compression:
//    80 rounds through the single shared round unit, then the chaining add.
//  - Finish: padding is shifted in one byte per cycle, with an extra block
//    when the 0x80 mark lands past byte 55; each padded block is compressed
//    likewise, then the five words are offered, one per cycle if not stalled.
//  - s_tready is low while a block compresses, while padding, and while the
//    digest is offered. If the receiver stalls, the current word holds
//    until taken; nothing is dropped.
//  - Reset (aresetn low, synchronous) loads the initial vector and clears
//    the byte count and bit length. After the fifth word the core returns
//    to the same state and the next transaction starts a new message.
module sha1_byte_stream_hash_core (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] byte_present
    input  logic        s_tlast,   // end_of_message
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast    // last_word
);
    import sha1bs_pkg::*;

    state_t            state_reg, state_next;
    logic [5:0]        fill_reg, fill_next;       // bytes pending in block
    logic [63:0]       len_reg, len_next;         // message length in bits
    logic [6:0]        cnt_reg, cnt_next;         // round counter
    logic [2:0]        idx_reg, idx_next;         // output word index
    logic              pend_reg, pend_next;       // end seen, finish after block
    logic              first_reg, first_next;     // next pad byte is the 0x80 mark
    logic              extra_reg, extra_next;     // mark landed past byte 55
    logic              done_reg, done_next;       // block in flight holds length
    logic [WORD_W-1:0] chain_reg [DIGEST_N];
    logic [WORD_W-1:0] chain_next [DIGEST_N];
    work_t             work_reg, work_next;
    logic [WORD_W-1:0] w_reg [BLOCK_N];           // byte shift line / schedule
    logic [WORD_W-1:0] w_next [BLOCK_N];

    work_t             round_out;
    logic              s_fire;
    logic              shift_en;
    logic [7:0]        shift_byte;
    logic              sched_en;
    logic [WORD_W-1:0] sched_word;
    logic              len_byte_sel;
    logic [7:0]        pad_byte;

    sha1bs_round u_round (
        .cur       (work_reg),
        .w_word    (w_reg[0]),
        .round_idx (cnt_reg),
        .nxt       (round_out)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = chain_reg[idx_reg];
    assign m_tuser  = idx_reg;
    assign m_tlast  = (idx_reg == OUT_LAST_IDX);

    // length bytes go in slots 56..63 of the final block only
    assign len_byte_sel = !first_reg && !extra_reg && (fill_reg >= FILL_LEN_START);
    assign pad_byte     = first_reg ? PAD_MARK : (len_byte_sel ? len_reg[63:56] : 8'h00);

    // W(t+16) = rotl1(W(t+13) ^ W(t+8) ^ W(t+2) ^ W(t))
    always_comb begin
        sched_word = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        sched_word = {sched_word[30:0], sched_word[31]};
    end

    // shift line: bytes enter big-endian at the tail; rounds shift whole words
    always_comb begin
        for (int i = 0; i < BLOCK_N; i++) begin
            w_next[i] = w_reg[i];
        end
        if (shift_en) begin
            for (int i = 0; i < BLOCK_N - 1; i++) begin
                w_next[i] = {w_reg[i][23:0], w_reg[i+1][31:24]};
            end
            w_next[BLOCK_N-1] = {w_reg[BLOCK_N-1][23:0], shift_byte};
        end else if (sched_en) begin
            for (int i = 0; i < BLOCK_N - 1; i++) begin
                w_next[i] = w_reg[i+1];
            end
            w_next[BLOCK_N-1] = sched_word;
        end
    end

    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        pend_next  = pend_reg;
        first_next = first_reg;
        extra_next = extra_reg;
        done_next  = done_reg;
        work_next  = work_reg;
        for (int i = 0; i < DIGEST_N; i++) begin
            chain_next[i] = chain_reg[i];
        end
        shift_en   = 1'b0;
        shift_byte = s_tdata;
        sched_en   = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    pend_next  = s_tlast;
                    first_next = 1'b1;
                    extra_next = 1'b0;
                    done_next  = 1'b0;
                    if (s_tuser[0]) begin
                        shift_en  = 1'b1;
                        fill_next = fill_reg + 6'd1;
                        len_next  = len_reg + BITS_PER_BYTE;
                    end
                    if (s_tuser[0] && (fill_reg == FILL_LAST)) begin
                        state_next = ST_ROUND;
                        work_next  = '{chain_reg[0], chain_reg[1], chain_reg[2],
                                       chain_reg[3], chain_reg[4]};
                        cnt_next   = '0;
                    end else if (s_tlast) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                shift_en   = 1'b1;
                shift_byte = pad_byte;
                fill_next  = fill_reg + 6'd1;
                first_next = 1'b0;
                if (len_byte_sel) begin
                    len_next = {len_reg[55:0], 8'h00};
                end
                if (fill_reg == FILL_LAST) begin
                    extra_next = 1'b0;
                    done_next  = len_byte_sel;
                    state_next = ST_ROUND;
                    work_next  = '{chain_reg[0], chain_reg[1], chain_reg[2],
                                   chain_reg[3], chain_reg[4]};
                    cnt_next   = '0;
                end else if (first_reg && (fill_reg >= FILL_LEN_START)) begin
                    extra_next = 1'b1;
                end
            end
            ST_ROUND: begin
                sched_en  = 1'b1;
                work_next = round_out;
                cnt_next  = cnt_reg + 7'd1;
                if (cnt_reg == RND_LAST) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                chain_next[0] = chain_reg[0] + work_reg.a;
                chain_next[1] = chain_reg[1] + work_reg.b;
                chain_next[2] = chain_reg[2] + work_reg.c;
                chain_next[3] = chain_reg[3] + work_reg.d;
                chain_next[4] = chain_reg[4] + work_reg.e;
                priority if (done_reg) begin
                    state_next = ST_OUT;
                    idx_next   = '0;
                end else if (pend_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    if (idx_reg == OUT_LAST_IDX) begin
                        for (int i = 0; i < DIGEST_N; i++) begin
                            chain_next[i] = IV_WORDS[i];
                        end
                        fill_next  = '0;
                        len_next   = '0;
                        pend_next  = 1'b0;
                        done_next  = 1'b0;
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            len_reg   <= '0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
            first_reg <= 1'b0;
            extra_reg <= 1'b0;
            done_reg  <= 1'b0;
            for (int i = 0; i < DIGEST_N; i++) begin
                chain_reg[i] <= IV_WORDS[i];
            end
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
            first_reg <= first_next;
            extra_reg <= extra_next;
            done_reg  <= done_next;
            for (int i = 0; i < DIGEST_N; i++) begin
                chain_reg[i] <= chain_next[i];
            end
        end
    end

    // payload: no reset
    always_ff @(posedge aclk) begin
        work_reg <= work_next;
        for (int i = 0; i < BLOCK_N; i++) begin
            w_reg[i] <= w_next[i];
        end
    end

endmodule

/* sv/sha1bs_checker.sv */
// Port-level checks for sha1_byte_stream_hash_core, attached by bind.
// Depends on the top level's port list only.
module sha1bs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // stalled digest word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("digest transaction changed while stalled");

    // no input taken while a digest is being offered
    a_no_in_during_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready while digest pending");

    // last flag marks word index four only
    a_last_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == 3'd4)) && (m_tuser <= 3'd4))
        else $error("word index and last flag disagree");

    // words follow each other without gaps in index
    a_idx_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && (m_tuser == $past(m_tuser) + 3'd1))
        else $error("digest words out of sequence");

    // after the final word the core is ready for a new message
    a_ready_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
        else $error("core not back to idle after digest");

endmodule

bind sha1_byte_stream_hash_core sha1bs_checker u_sha1bs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
